// ===== design/gfl_pkg.sv =====
// Shared types and constants for the growing free-list cell allocator.
`default_nettype none

package gfl_pkg;

    localparam int IDX_W  = 12;
    localparam int LIVE_W = 13;

    localparam int MAX_CELLS_DEF     = 4096;
    localparam int INITIAL_CELLS_DEF = 256;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]  granted_index;
        logic              out_of_memory;
        logic              bad_index;
        logic              pool_grew;
        logic [LIVE_W-1:0] live_cells;
    } t_result;

endpackage

`default_nettype wire

// ===== design/gfl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module gfl_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/gfl_out_stage.sv =====
// Result output register with a one-word skid slot behind it.
`default_nettype none

module gfl_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  gfl_pkg::t_result      i_word,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output gfl_pkg::t_result      o_word
);

    import gfl_pkg::*;

    logic    r_out_valid;
    logic    r_hold_valid;
    t_result r_out;
    t_result r_hold;
    logic    drain;

    assign drain   = r_out_valid && i_ready;
    assign o_full  = r_hold_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (r_hold_valid) begin
            // advance the held word once the output word is taken
            if (drain) begin
                r_out        <= r_hold;
                r_hold_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || drain) begin
                r_out       <= i_word;
                r_out_valid <= 1'b1;
            end else begin
                r_hold       <= i_word;
                r_hold_valid <= 1'b1;
            end
        end else if (drain) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== design/growing_free_list_cell_allocator.sv =====
// Top level: LIFO free-list cell allocator with a doubling active pool.
// A free, a fresh-cell allocate or an out-of-memory allocate pushes its result
// when accepted; an allocate that pops the free list first passes ST_POP, where the link RAM read returns the new head.
// Each result is registered in the output stage, or in its skid slot while the output word is stalled.
// Reset (synchronous, active low) empties the list, sets the pool to its
// initial size and clears the counts; the link RAM is not cleared.
`default_nettype none

module growing_free_list_cell_allocator #(
    parameter int MAX_CELLS     = gfl_pkg::MAX_CELLS_DEF,
    parameter int INITIAL_CELLS = gfl_pkg::INITIAL_CELLS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_command,
    input  wire logic [gfl_pkg::IDX_W-1:0]  i_cell_index,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [gfl_pkg::IDX_W-1:0]  o_granted_index,
    output logic                            o_out_of_memory,
    output logic                            o_bad_index,
    output logic                            o_pool_grew,
    output logic      [gfl_pkg::LIVE_W-1:0] o_live_cells
);

    import gfl_pkg::*;

    localparam int PTR_W  = $clog2(MAX_CELLS + 1);
    localparam int ADDR_W = $clog2(MAX_CELLS);
    localparam int CMP_W  = (PTR_W > IDX_W) ? PTR_W : IDX_W;
    localparam int LIMIT0 = (INITIAL_CELLS > MAX_CELLS) ? MAX_CELLS : INITIAL_CELLS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic              r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_fresh, n_fresh;
    logic [PTR_W-1:0]  r_limit, n_limit;
    logic [LIVE_W-1:0] r_live, n_live;
    t_result           r_pop_res, n_pop_res;

    logic              accept;
    logic              head_valid;
    logic              idx_bad;
    logic [PTR_W:0]    limit2;
    logic              can_grow;
    logic              rd_en;
    logic              wr_en;
    logic [PTR_W-1:0]  rd_data;
    logic              push;
    logic              hold_full;
    t_result           res;
    t_result           push_word;
    t_result           out_word;

    assign o_ready    = (r_state == ST_IDLE) && !hold_full;
    assign accept     = i_valid && o_ready;
    assign head_valid = r_head < PTR_W'(MAX_CELLS);
    assign idx_bad    = CMP_W'(i_cell_index) >= CMP_W'(r_limit);
    assign limit2     = {r_limit, 1'b0};
    assign can_grow   = limit2 <= (PTR_W + 1)'(MAX_CELLS);
    assign rd_en      = accept && (i_command == CMD_ALLOC) && head_valid;
    assign wr_en      = accept && (i_command == CMD_FREE) && !idx_bad;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_fresh   = r_fresh;
        n_limit   = r_limit;
        n_live    = r_live;
        n_pop_res = r_pop_res;
        res       = '0;
        push      = 1'b0;
        push_word = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        CMD_ALLOC: begin
                            if (head_valid) begin
                                // new head arrives from the link RAM next cycle
                                n_live            = r_live + 1'b1;
                                res.granted_index = IDX_W'(r_head);
                                n_state           = ST_POP;
                            end else if (r_fresh < r_limit) begin
                                n_live            = r_live + 1'b1;
                                res.granted_index = IDX_W'(r_fresh);
                                n_fresh           = r_fresh + 1'b1;
                            end else if (can_grow) begin
                                n_live            = r_live + 1'b1;
                                res.granted_index = IDX_W'(r_fresh);
                                res.pool_grew     = 1'b1;
                                n_fresh           = r_fresh + 1'b1;
                                n_limit           = limit2[PTR_W-1:0];
                            end else begin
                                res.out_of_memory = 1'b1;
                            end
                        end
                        CMD_FREE: begin
                            if (idx_bad) begin
                                res.bad_index = 1'b1;
                            end else begin
                                n_head = PTR_W'(i_cell_index);
                                n_live = r_live - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    res.live_cells = n_live;
                    n_pop_res      = res;
                    push           = (n_state == ST_IDLE);
                    push_word      = res;
                end
            end
            ST_POP: begin
                n_head    = rd_data;
                n_state   = ST_IDLE;
                push      = 1'b1;
                push_word = r_pop_res;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= PTR_W'(MAX_CELLS);
            r_fresh <= '0;
            r_limit <= PTR_W'(LIMIT0);
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fresh <= n_fresh;
            r_limit <= n_limit;
            r_live  <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_res <= n_pop_res;
    end

    gfl_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_CELLS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(i_cell_index)),
        .i_wr_data (r_head),
        .i_rd_en   (rd_en),
        .i_rd_addr (ADDR_W'(r_head)),
        .o_rd_data (rd_data)
    );

    gfl_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (hold_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (out_word)
    );

    assign o_granted_index = out_word.granted_index;
    assign o_out_of_memory = out_word.out_of_memory;
    assign o_bad_index     = out_word.bad_index;
    assign o_pool_grew     = out_word.pool_grew;
    assign o_live_cells    = out_word.live_cells;

endmodule

`default_nettype wire

// ===== design/gfl_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`default_nettype none

module gfl_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic                       i_command,
    input wire logic [gfl_pkg::IDX_W-1:0]  i_cell_index,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic [gfl_pkg::IDX_W-1:0]  o_granted_index,
    input wire logic                       o_out_of_memory,
    input wire logic                       o_bad_index,
    input wire logic                       o_pool_grew,
    input wire logic [gfl_pkg::LIVE_W-1:0] o_live_cells
);

    // hold a command word that has not been taken yet
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_command) && $stable(i_cell_index))
        else $error("waiting command word changed");

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_granted_index)
            && $stable(o_live_cells) && $stable(o_out_of_memory))
        else $error("stalled result word changed");

    a_oom_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_memory |-> o_granted_index == '0 && !o_pool_grew
            && !o_bad_index)
        else $error("out of memory result carries a grant");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_index |-> o_granted_index == '0 && !o_pool_grew
            && !o_out_of_memory)
        else $error("bad free result carries other flags");

    a_grow_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pool_grew |-> !o_out_of_memory && !o_bad_index)
        else $error("growth flagged together with a failure");

endmodule

bind growing_free_list_cell_allocator gfl_checker u_gfl_checker (.*);

`default_nettype wire

// ===== tb/tb_growing_free_list_cell_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the growing free-list cell allocator.
module tb_growing_free_list_cell_allocator;
    import gfl_pkg::*;

    localparam int MAX_CELLS       = MAX_CELLS_DEF;
    localparam int INITIAL_CELLS   = INITIAL_CELLS_DEF;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 80;
    localparam int RANDOM_WORDS    = 270;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_MOSTLY
    } t_rx_mode;

    // Mirror of the allocator: free list, fresh pointer, pool size and counts.
    class free_list_mirror;
        logic [LIVE_W-1:0] links [MAX_CELLS];
        logic [LIVE_W-1:0] head;
        logic [LIVE_W-1:0] fresh;
        logic [LIVE_W-1:0] limit;
        logic [31:0]       allocs;
        logic [31:0]       frees;
        t_result           pending[$];
        logic [IDX_W-1:0]  held[$];
        int                accepted;
        int                checked;
        int                errors;
        int                grew_seen;
        int                oom_seen;
        int                bad_seen;

        function new();
            head      = LIVE_W'(MAX_CELLS);
            fresh     = '0;
            limit     = LIVE_W'((INITIAL_CELLS > MAX_CELLS) ? MAX_CELLS : INITIAL_CELLS);
            allocs    = '0;
            frees     = '0;
            accepted  = 0;
            checked   = 0;
            errors    = 0;
            grew_seen = 0;
            oom_seen  = 0;
            bad_seen  = 0;
        endfunction

        function void record_command(logic cmd, logic [IDX_W-1:0] idx);
            t_result     r;
            logic [31:0] diff;
            int          pos[$];
            r = '0;
            if (cmd == CMD_ALLOC) begin
                if (head < LIVE_W'(MAX_CELLS)) begin
                    r.granted_index = head[IDX_W-1:0];
                    head = links[head];
                    allocs++;
                end else if (fresh < limit) begin
                    r.granted_index = fresh[IDX_W-1:0];
                    fresh++;
                    allocs++;
                end else if (int'(limit) * 2 <= MAX_CELLS && limit != 0) begin
                    limit = limit << 1;
                    r.pool_grew = 1'b1;
                    r.granted_index = fresh[IDX_W-1:0];
                    fresh++;
                    allocs++;
                    grew_seen++;
                end else begin
                    r.out_of_memory = 1'b1;
                    oom_seen++;
                end
                if (!r.out_of_memory) held.push_back(r.granted_index);
            end else if ({1'b0, idx} >= limit) begin
                r.bad_index = 1'b1;
                bad_seen++;
            end else begin
                links[idx] = head;
                head = {1'b0, idx};
                frees++;
                pos = held.find_first_index(item) with (item == idx);
                if (pos.size() != 0) held.delete(pos[0]);
            end
            diff = allocs - frees;
            r.live_cells = diff[LIVE_W-1:0];
            pending.push_back(r);
            accepted++;
        endfunction

        function void check_reply(logic [IDX_W-1:0] g, logic oom, logic bad, logic grew,
                                  logic [LIVE_W-1:0] live);
            t_result e;
            if (pending.size() == 0) begin
                $error("result word with no command outstanding: granted_index %0d", g);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (g !== e.granted_index) begin
                $error("granted_index: expected %0d, got %0d", e.granted_index, g);
                errors++;
            end
            if (oom !== e.out_of_memory) begin
                $error("out_of_memory: expected %0b, got %0b", e.out_of_memory, oom);
                errors++;
            end
            if (bad !== e.bad_index) begin
                $error("bad_index: expected %0b, got %0b", e.bad_index, bad);
                errors++;
            end
            if (grew !== e.pool_grew) begin
                $error("pool_grew: expected %0b, got %0b", e.pool_grew, grew);
                errors++;
            end
            if (live !== e.live_cells) begin
                $error("live_cells: expected %0d, got %0d", e.live_cells, live);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic              i_command    = CMD_ALLOC;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    logic [IDX_W-1:0]  o_granted_index;
    logic              o_out_of_memory;
    logic              o_bad_index;
    logic              o_pool_grew;
    logic [LIVE_W-1:0] o_live_cells;

    free_list_mirror ledger = new();
    int              burst_left = 0;
    int              cycles = 0;
    int              rx_cycle = 0;
    bit              held_off = 1'b0;

    growing_free_list_cell_allocator #(
        .MAX_CELLS     (MAX_CELLS),
        .INITIAL_CELLS (INITIAL_CELLS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_cell_index    (i_cell_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_granted_index (o_granted_index),
        .o_out_of_memory (o_out_of_memory),
        .o_bad_index     (o_bad_index),
        .o_pool_grew     (o_pool_grew),
        .o_live_cells    (o_live_cells)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $error("cycle limit of %0d reached with %0d words outstanding",
                   CYCLE_LIMIT, ledger.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            ledger.check_reply(o_granted_index, o_out_of_memory, o_bad_index,
                               o_pool_grew, o_live_cells);
        end
    end

    // Offer one command word in bursts; hold it until the block takes it.
    task automatic offer(input logic cmd, input logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_cell_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        ledger.record_command(cmd, idx);
    endtask

    // Receiver: stall on shifting patterns, and hold off once for a long stretch.
    initial begin
        t_rx_mode mode;
        int       span;
        wait (i_rst_n);
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge i_clk);
                rx_cycle++;
                case (mode)
                    RX_OPEN:         i_ready <= 1'b1;
                    RX_COIN:         i_ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: i_ready <= (rx_cycle % 4 == 0);
                    default:         i_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
            if (!held_off && ledger.accepted >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        int roll;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Stray free at reset wraps the live count, bad frees at and above the pool edge.
        offer(CMD_FREE, 12'd0);
        offer(CMD_ALLOC, 12'hFFF);
        offer(CMD_FREE, 12'hFFF);
        offer(CMD_FREE, 12'(INITIAL_CELLS));
        offer(CMD_FREE, 12'(INITIAL_CELLS - 1));
        offer(CMD_ALLOC, 12'h000);
        // Fresh cells, then LIFO reuse, then back to fresh.
        offer(CMD_ALLOC, 12'h555);
        offer(CMD_ALLOC, 12'hAAA);
        offer(CMD_ALLOC, 12'h000);
        offer(CMD_FREE, 12'd2);
        offer(CMD_FREE, 12'd1);
        offer(CMD_ALLOC, 12'hFFF);
        offer(CMD_ALLOC, 12'h000);
        offer(CMD_ALLOC, 12'h123);

        // Use up the initial pool until it doubles once.
        while (ledger.grew_seen < 1) offer(CMD_ALLOC, 12'($urandom));

        // Grown pool: top index still out of range, LIFO order, then a double free.
        offer(CMD_FREE, 12'hFFF);
        offer(CMD_ALLOC, 12'h000);
        offer(CMD_ALLOC, 12'hFFF);
        offer(CMD_FREE, 12'd10);
        offer(CMD_FREE, 12'd20);
        offer(CMD_ALLOC, 12'h000);
        offer(CMD_ALLOC, 12'h000);
        offer(CMD_FREE, 12'd30);
        offer(CMD_FREE, 12'd30);
        offer(CMD_ALLOC, 12'h000);
        offer(CMD_ALLOC, 12'h000);

        // Allocates half the time, else mostly frees of cells handed out, with stray frees as noise.
        repeat (RANDOM_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                offer(CMD_ALLOC, 12'($urandom));
            else if (roll < 88 && ledger.held.size() != 0)
                offer(CMD_FREE, ledger.held[$urandom_range(0, ledger.held.size() - 1)]);
            else
                offer(CMD_FREE, 12'($urandom));
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands and %0d result words checked.",
                 ledger.accepted, ledger.checked);
        $display("Seen: %0d pool doublings, %0d out-of-memory replies, %0d rejected frees.",
                 ledger.grew_seen, ledger.oom_seen, ledger.bad_seen);
        if (ledger.errors == 0 && ledger.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
